FILE: sv/spse_pkg.sv
// Shared types and constants for the sprite serialiser engine.
`timescale 1ns / 1ps

package spse_pkg;

    // Request opcodes; the two top codes are unused and change nothing
    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_LINE  = 3'd2,
        OP_DMA   = 3'd3,
        OP_QUERY = 3'd4,
        OP_SHIFT = 3'd5
    } opcode_t;

    // Write selectors
    localparam logic [3:0] WR_POS    = 4'd0;
    localparam logic [3:0] WR_CTL    = 4'd1;
    localparam logic [3:0] WR_DATA_A = 4'd2;
    localparam logic [3:0] WR_DATA_B = 4'd3;
    localparam logic [3:0] WR_PTR_HI = 4'd4;
    localparam logic [3:0] WR_PTR_LO = 4'd5;

    // Read selectors
    localparam logic [3:0] RD_POS      = 4'd0;
    localparam logic [3:0] RD_CTL      = 4'd1;
    localparam logic [3:0] RD_DATA_A   = 4'd2;
    localparam logic [3:0] RD_DATA_B   = 4'd3;
    localparam logic [3:0] RD_PTR      = 4'd4;
    localparam logic [3:0] RD_HSTART   = 4'd5;
    localparam logic [3:0] RD_VSTART   = 4'd6;
    localparam logic [3:0] RD_VSTOP    = 4'd7;
    localparam logic [3:0] RD_ATTACHED = 4'd8;

    localparam logic [3:0]  NO_SPRITE   = 4'd8;
    localparam logic [31:0] ABSENT_WORD = 32'h0000_ffff;
    localparam logic [4:0]  BITS_FULL   = 5'd16;

    // One request
    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  sprite;
        logic [3:0]  reg_sel;
        logic [15:0] value;
        logic [8:0]  line;
        logic [8:0]  hpos;
    } cmd_t;

    // One result
    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  pixel;
        logic [3:0]  pixel_sprite;
        logic [7:0]  dma_request;
    } res_t;

    // Request broadcast to every cell
    typedef struct packed {
        logic fire;
        cmd_t cmd;
    } cell_bus_t;

    // Link handed from one cell to the next
    typedef struct packed {
        logic [3:0]  idx;
        logic        found;
        logic [1:0]  pixel;
        logic [3:0]  who;
        logic [31:0] read_data;
    } chain_t;

endpackage

FILE: sv/sprite_serializer_engine.sv
// Top level of the sprite serialiser engine: a row of sprite cells and the result register.
`timescale 1ns / 1ps

// Takes one request per clock and returns exactly one result per request, in the
// cycle after acceptance, from a result register. All sprite cells update in
// parallel in the cycle a request is accepted; the pixel priority search and
// the register read ripple through the row of cells within that same cycle,
// so sustained throughput is one request per clock whenever the result side
// does not stall. A stalled result holds the request side off only while it
// is both valid and stalled. SPRITE_COUNT sets the number of cells (1 to 8);
// requests naming a sprite beyond it write nothing, and reads of its position,
// control or data words return 0xffff.
module sprite_serializer_engine #(
    parameter int SPRITE_COUNT = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  spse_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output spse_pkg::res_t  res
);

    localparam logic [3:0] CELL_LIMIT = 4'(SPRITE_COUNT);

    spse_pkg::cell_bus_t bus;
    spse_pkg::chain_t    links [SPRITE_COUNT + 1];
    logic [7:0]          due;
    logic                accept;
    logic                absent;
    spse_pkg::res_t      res_next;
    spse_pkg::res_t      res_reg;
    logic                res_valid_reg, res_valid_next;

    // Handshake
    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign bus.fire = accept;
    assign bus.cmd  = cmd;

    // Head of the chain
    assign links[0].idx       = 4'd0;
    assign links[0].found     = 1'b0;
    assign links[0].pixel     = 2'd0;
    assign links[0].who       = spse_pkg::NO_SPRITE;
    assign links[0].read_data = 32'd0;

    // Row of sprite cells
    for (genvar gi = 0; gi < 8; gi++)
    begin : g_cell
        if (gi < SPRITE_COUNT)
        begin : g_on
            spse_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .bus       (bus),
                .link_in   (links[gi]),
                .link_out  (links[gi + 1]),
                .fetch_due (due[gi])
            );
        end
        else
        begin : g_off
            assign due[gi] = 1'b0;
        end
    end

    // Result assembly
    assign absent = ({1'b0, cmd.sprite} >= CELL_LIMIT);

    always_comb
    begin
        res_next.read_data    = links[SPRITE_COUNT].read_data;
        res_next.pixel        = links[SPRITE_COUNT].pixel;
        res_next.pixel_sprite = links[SPRITE_COUNT].who;
        res_next.dma_request  = due;
        if ((cmd.opcode == spse_pkg::OP_READ) && absent)
        begin
            res_next.read_data = (cmd.reg_sel <= spse_pkg::RD_DATA_B) ?
                                 spse_pkg::ABSENT_WORD : 32'd0;
        end
    end

    // Result register valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: sv/spse_cell.sv
// One sprite cell: its registers, line/fetch/shift logic and its link of the priority chain.
`timescale 1ns / 1ps

module spse_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spse_pkg::cell_bus_t  bus,
    input  spse_pkg::chain_t     link_in,
    output spse_pkg::chain_t     link_out,
    output logic                 fetch_due
);

    logic [15:0] pos_reg,     pos_next;
    logic [15:0] ctl_reg,     ctl_next;
    logic [15:0] data_a_reg,  data_a_next;
    logic [15:0] data_b_reg,  data_b_next;
    logic [15:0] shift_a_reg, shift_a_next;
    logic [15:0] shift_b_reg, shift_b_next;
    logic [15:0] ptr_hi_reg,  ptr_hi_next;
    logic [15:1] ptr_lo_reg,  ptr_lo_next;
    logic [31:1] fptr_reg,    fptr_next;
    logic [4:0]  bits_reg,    bits_next;
    logic        armed_reg,   armed_next;
    logic        shown_reg,   shown_next;
    logic        online_reg,  online_next;
    logic [1:0]  pending_reg, pending_next;

    logic        me;
    logic [8:0]  hstart;
    logic [8:0]  vstart;
    logic [8:0]  vstop;
    logic        on_now;
    logic [8:0]  hoff;
    logic        in_window;
    logic [1:0]  pix;
    logic        eligible;
    logic [31:0] rd_val;

    // Fields derived from position and control words
    assign me        = (bus.cmd.sprite == link_in.idx[2:0]);
    assign hstart    = {pos_reg[7:0], ctl_reg[0]};
    assign vstart    = {ctl_reg[2], pos_reg[15:8]};
    assign vstop     = {ctl_reg[1], ctl_reg[15:8]};
    assign on_now    = (bus.cmd.line >= vstart) && (bus.cmd.line < vstop);
    assign hoff      = bus.cmd.hpos - hstart;
    assign in_window = (bus.cmd.hpos >= hstart) && (hoff[8:4] == 5'd0);
    assign pix       = {shift_b_reg[15], shift_a_reg[15]};
    assign eligible  = shown_reg && armed_reg && (bits_reg != 5'd0);

    // State update
    always_comb
    begin
        pos_next     = pos_reg;
        ctl_next     = ctl_reg;
        data_a_next  = data_a_reg;
        data_b_next  = data_b_reg;
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        ptr_hi_next  = ptr_hi_reg;
        ptr_lo_next  = ptr_lo_reg;
        fptr_next    = fptr_reg;
        bits_next    = bits_reg;
        armed_next   = armed_reg;
        shown_next   = shown_reg;
        online_next  = online_reg;
        pending_next = pending_reg;
        if (bus.fire)
        begin
            case (bus.cmd.opcode)
                spse_pkg::OP_WRITE:
                begin
                    if (me)
                    begin
                        case (bus.cmd.reg_sel)
                            spse_pkg::WR_POS: pos_next = bus.cmd.value;
                            spse_pkg::WR_CTL: ctl_next = bus.cmd.value;
                            spse_pkg::WR_DATA_A:
                            begin
                                data_a_next  = bus.cmd.value;
                                shift_a_next = bus.cmd.value;
                                bits_next    = spse_pkg::BITS_FULL;
                                armed_next   = 1'b1;
                            end
                            spse_pkg::WR_DATA_B:
                            begin
                                data_b_next  = bus.cmd.value;
                                shift_b_next = bus.cmd.value;
                                bits_next    = spse_pkg::BITS_FULL;
                                armed_next   = 1'b1;
                            end
                            spse_pkg::WR_PTR_HI:
                            begin
                                ptr_hi_next = bus.cmd.value;
                                fptr_next   = {bus.cmd.value, ptr_lo_reg};
                            end
                            spse_pkg::WR_PTR_LO:
                            begin
                                ptr_lo_next = bus.cmd.value[15:1];
                                fptr_next   = {ptr_hi_reg, bus.cmd.value[15:1]};
                            end
                            default: ;
                        endcase
                    end
                end
                spse_pkg::OP_LINE:
                begin
                    online_next  = on_now;
                    shown_next   = 1'b0;
                    pending_next = 2'd0;
                    if (on_now && (fptr_reg == '0) &&
                        ((data_a_reg != 16'd0) || (data_b_reg != 16'd0)))
                    begin
                        shift_a_next = data_a_reg;
                        shift_b_next = data_b_reg;
                        bits_next    = spse_pkg::BITS_FULL;
                        armed_next   = 1'b1;
                        shown_next   = 1'b1;
                    end
                    else
                    begin
                        bits_next  = 5'd0;
                        armed_next = 1'b0;
                        if (on_now && (fptr_reg != '0))
                        begin
                            pending_next = 2'd2;
                        end
                    end
                end
                spse_pkg::OP_DMA:
                begin
                    if (me && online_reg && (pending_reg != 2'd0))
                    begin
                        // pointer steps by one word and wraps in 24 bits
                        fptr_next = {8'd0, fptr_reg[23:1] + 23'd1};
                        if (pending_reg == 2'd2)
                        begin
                            data_a_next  = bus.cmd.value;
                            pending_next = 2'd1;
                        end
                        else
                        begin
                            data_b_next  = bus.cmd.value;
                            shift_a_next = data_a_reg;
                            shift_b_next = bus.cmd.value;
                            bits_next    = spse_pkg::BITS_FULL;
                            armed_next   = 1'b1;
                            shown_next   = 1'b1;
                            pending_next = 2'd0;
                        end
                    end
                end
                spse_pkg::OP_SHIFT:
                begin
                    if (armed_reg && (bits_reg != 5'd0))
                    begin
                        shift_a_next = {shift_a_reg[14:0], 1'b0};
                        shift_b_next = {shift_b_reg[14:0], 1'b0};
                        bits_next    = bits_reg - 5'd1;
                        if (bits_reg == 5'd1)
                        begin
                            armed_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Register or derived field seen by a read
    always_comb
    begin
        case (bus.cmd.reg_sel)
            spse_pkg::RD_POS:      rd_val = {16'd0, pos_reg};
            spse_pkg::RD_CTL:      rd_val = {16'd0, ctl_reg};
            spse_pkg::RD_DATA_A:   rd_val = {16'd0, data_a_reg};
            spse_pkg::RD_DATA_B:   rd_val = {16'd0, data_b_reg};
            spse_pkg::RD_PTR:      rd_val = {fptr_reg, 1'b0};
            spse_pkg::RD_HSTART:   rd_val = {23'd0, hstart};
            spse_pkg::RD_VSTART:   rd_val = {23'd0, vstart};
            spse_pkg::RD_VSTOP:    rd_val = {23'd0, vstop};
            spse_pkg::RD_ATTACHED: rd_val = {31'd0, ctl_reg[7]};
            default:               rd_val = 32'd0;
        endcase
    end

    // Chain link: the first cell with a visible pixel wins, the addressed cell supplies reads
    always_comb
    begin
        link_out     = link_in;
        link_out.idx = link_in.idx + 4'd1;
        if ((bus.cmd.opcode == spse_pkg::OP_READ) && me)
        begin
            link_out.read_data = rd_val;
        end
        if ((bus.cmd.opcode == spse_pkg::OP_QUERY) && !link_in.found && eligible &&
            in_window && (pix != 2'd0))
        begin
            link_out.found = 1'b1;
            link_out.pixel = pix;
            link_out.who   = link_in.idx;
        end
    end

    // Fetch request seen after this request's update
    assign fetch_due = online_next && (pending_next != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            ctl_reg     <= '0;
            data_a_reg  <= '0;
            data_b_reg  <= '0;
            shift_a_reg <= '0;
            shift_b_reg <= '0;
            ptr_hi_reg  <= '0;
            ptr_lo_reg  <= '0;
            fptr_reg    <= '0;
            bits_reg    <= '0;
            armed_reg   <= 1'b0;
            shown_reg   <= 1'b0;
            online_reg  <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            ctl_reg     <= ctl_next;
            data_a_reg  <= data_a_next;
            data_b_reg  <= data_b_next;
            shift_a_reg <= shift_a_next;
            shift_b_reg <= shift_b_next;
            ptr_hi_reg  <= ptr_hi_next;
            ptr_lo_reg  <= ptr_lo_next;
            fptr_reg    <= fptr_next;
            bits_reg    <= bits_next;
            armed_reg   <= armed_next;
            shown_reg   <= shown_next;
            online_reg  <= online_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: sv/spse_checker.sv
// Port-level checks for the sprite serialiser engine, bound to the top level.
`timescale 1ns / 1ps

module spse_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input logic           res_valid,
    input logic           res_stall,
    input spse_pkg::res_t res
);

    // An accepted request always yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> res_valid)
        else $error("accepted request produced no result");

    // A waiting result is never overwritten by a new request
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> cmd_stall)
        else $error("request side open while result is stalled");

    // A pixel is non-transparent exactly when a sprite is named
    a_pixel_owner: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.pixel == 2'd0) == (res.pixel_sprite == spse_pkg::NO_SPRITE)))
        else $error("pixel and pixel_sprite disagree");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind sprite_serializer_engine spse_checker u_spse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the sprite serialiser engine: driver, monitor and result predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int SPRITES      = 8;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_TAIL    = 80;

    // Opcodes and selectors that the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [3:0] SEL_GAP     = 4'd9;
    localparam logic [3:0] SEL_BAD     = 4'd15;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    spse_pkg::cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    spse_pkg::res_t res;

    sprite_serializer_engine #(
        .SPRITE_COUNT(SPRITES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    always #2 clk = ~clk;

    // Requests waiting to go out, and results predicted but not yet seen
    spse_pkg::cmd_t req_q[$];
    spse_pkg::res_t pixel_results[$];
    int   errs = 0;

    // Predictor copy of the per-sprite state
    logic [15:0] pos_w[SPRITES];
    logic [15:0] ctl_w[SPRITES];
    logic [15:0] dat_a[SPRITES];
    logic [15:0] dat_b[SPRITES];
    logic [15:0] shf_a[SPRITES];
    logic [15:0] shf_b[SPRITES];
    logic [15:0] ptr_hi[SPRITES];
    logic [15:0] ptr_lo[SPRITES];
    logic [31:0] fetch_ptr[SPRITES];
    logic [4:0]  bits_left[SPRITES];
    logic        armed[SPRITES];
    logic        shown[SPRITES];
    logic        on_line[SPRITES];
    logic [1:0]  pending[SPRITES];

    initial
    begin
        for (int i = 0; i < SPRITES; i++)
        begin
            pos_w[i] = '0;  ctl_w[i] = '0;  dat_a[i] = '0;  dat_b[i] = '0;
            shf_a[i] = '0;  shf_b[i] = '0;  ptr_hi[i] = '0; ptr_lo[i] = '0;
            fetch_ptr[i] = '0; bits_left[i] = '0;
            armed[i] = 1'b0; shown[i] = 1'b0; on_line[i] = 1'b0; pending[i] = '0;
        end
    end

    function automatic logic [8:0] h_start(int i);
        return {pos_w[i][7:0], ctl_w[i][0]};
    endfunction

    function automatic logic [8:0] v_start(int i);
        return {ctl_w[i][2], pos_w[i][15:8]};
    endfunction

    function automatic logic [8:0] v_stop(int i);
        return {ctl_w[i][1], ctl_w[i][15:8]};
    endfunction

    // Copy data words into the shifters and arm the sprite
    function automatic void spr_reload(int i);
        shf_a[i]     = dat_a[i];
        shf_b[i]     = dat_b[i];
        bits_left[i] = spse_pkg::BITS_FULL;
        armed[i]     = 1'b1;
    endfunction

    // Apply one request to the predicted state and return the result it gives
    function automatic spse_pkg::res_t sprite_step(spse_pkg::cmd_t c);
        spse_pkg::res_t r;
        int   s;
        logic act;
        logic found;
        logic [1:0] px;
        r = '0;
        r.pixel_sprite = spse_pkg::NO_SPRITE;
        s = int'(c.sprite);
        found = 1'b0;
        case (c.opcode)
            spse_pkg::OP_WRITE:
            begin
                if (s < SPRITES)
                begin
                    case (c.reg_sel)
                        spse_pkg::WR_POS: pos_w[s] = c.value;
                        spse_pkg::WR_CTL: ctl_w[s] = c.value;
                        spse_pkg::WR_DATA_A:
                        begin
                            dat_a[s] = c.value; shf_a[s] = c.value;
                            bits_left[s] = spse_pkg::BITS_FULL; armed[s] = 1'b1;
                        end
                        spse_pkg::WR_DATA_B:
                        begin
                            dat_b[s] = c.value; shf_b[s] = c.value;
                            bits_left[s] = spse_pkg::BITS_FULL; armed[s] = 1'b1;
                        end
                        spse_pkg::WR_PTR_HI:
                        begin
                            ptr_hi[s]    = c.value;
                            fetch_ptr[s] = {ptr_hi[s], ptr_lo[s]};
                        end
                        spse_pkg::WR_PTR_LO:
                        begin
                            ptr_lo[s]    = c.value & 16'hfffe;
                            fetch_ptr[s] = {ptr_hi[s], ptr_lo[s]};
                        end
                        default: ;
                    endcase
                end
            end
            spse_pkg::OP_READ:
            begin
                if (s >= SPRITES)
                begin
                    r.read_data = (c.reg_sel <= spse_pkg::RD_DATA_B) ?
                                  spse_pkg::ABSENT_WORD : 32'd0;
                end
                else
                begin
                    case (c.reg_sel)
                        spse_pkg::RD_POS:      r.read_data = {16'd0, pos_w[s]};
                        spse_pkg::RD_CTL:      r.read_data = {16'd0, ctl_w[s]};
                        spse_pkg::RD_DATA_A:   r.read_data = {16'd0, dat_a[s]};
                        spse_pkg::RD_DATA_B:   r.read_data = {16'd0, dat_b[s]};
                        spse_pkg::RD_PTR:      r.read_data = fetch_ptr[s];
                        spse_pkg::RD_HSTART:   r.read_data = {23'd0, h_start(s)};
                        spse_pkg::RD_VSTART:   r.read_data = {23'd0, v_start(s)};
                        spse_pkg::RD_VSTOP:    r.read_data = {23'd0, v_stop(s)};
                        spse_pkg::RD_ATTACHED: r.read_data = {31'd0, ctl_w[s][7]};
                        default:               r.read_data = 32'd0;
                    endcase
                end
            end
            spse_pkg::OP_LINE:
            begin
                for (int i = 0; i < SPRITES; i++)
                begin
                    act = (c.line >= v_start(i)) && (c.line < v_stop(i));
                    on_line[i] = act;
                    shown[i]   = 1'b0;
                    pending[i] = '0;
                    if (act && fetch_ptr[i] == '0 && (dat_a[i] != '0 || dat_b[i] != '0))
                    begin
                        spr_reload(i);
                        shown[i] = 1'b1;
                    end
                    else
                    begin
                        bits_left[i] = '0;
                        armed[i]     = 1'b0;
                        if (act && fetch_ptr[i] != '0)
                        begin
                            pending[i] = 2'd2;
                        end
                    end
                end
            end
            spse_pkg::OP_DMA:
            begin
                if (s < SPRITES && on_line[s] && pending[s] != '0)
                begin
                    fetch_ptr[s] = (fetch_ptr[s] + 32'd2) & 32'h00ff_fffe;
                    if (pending[s] == 2'd2)
                    begin
                        dat_a[s]   = c.value;
                        pending[s] = 2'd1;
                    end
                    else
                    begin
                        dat_b[s] = c.value;
                        spr_reload(s);
                        shown[s]   = 1'b1;
                        pending[s] = '0;
                    end
                end
            end
            spse_pkg::OP_QUERY:
            begin
                for (int i = 0; i < SPRITES; i++)
                begin
                    if (!found && shown[i] && armed[i] && bits_left[i] != '0
                            && c.hpos >= h_start(i) && c.hpos - h_start(i) < 9'd16)
                    begin
                        px = {shf_b[i][15], shf_a[i][15]};
                        if (px != '0)
                        begin
                            r.pixel        = px;
                            r.pixel_sprite = 4'(i);
                            found          = 1'b1;
                        end
                    end
                end
            end
            spse_pkg::OP_SHIFT:
            begin
                for (int i = 0; i < SPRITES; i++)
                begin
                    if (armed[i] && bits_left[i] != '0)
                    begin
                        shf_a[i]     = shf_a[i] << 1;
                        shf_b[i]     = shf_b[i] << 1;
                        bits_left[i] = bits_left[i] - 5'd1;
                        if (bits_left[i] == '0)
                        begin
                            armed[i] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        // Fetch request mask after the update
        for (int i = 0; i < SPRITES; i++)
        begin
            if (on_line[i] && pending[i] != '0)
            begin
                r.dma_request[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // Stimulus helpers
    task automatic add_req(logic [2:0] op, logic [2:0] spr, logic [3:0] sel,
                           logic [15:0] val, logic [8:0] ln, logic [8:0] hp);
        spse_pkg::cmd_t c;
        c.opcode  = op;
        c.sprite  = spr;
        c.reg_sel = sel;
        c.value   = val;
        c.line    = ln;
        c.hpos    = hp;
        req_q.push_back(c);
    endtask

    // One display line: place some sprites around a line, fetch their words, then scan
    task automatic add_scene();
        logic [8:0]  ln, hbase, vs, ve, hs;
        logic [7:0]  used;
        logic [4:0]  ctl_mid;
        logic [15:0] hi, lo;
        int          s, k, round;
        ln    = 9'($urandom_range(0, 511));
        hbase = 9'($urandom_range(0, 490));
        used  = 8'($urandom);
        for (s = 0; s < SPRITES; s++)
        begin
            if (used[s])
            begin
                vs = (ln < 9'd4) ? 9'($urandom_range(0, ln)) :
                                   9'($urandom_range(ln - 9'd4, ln));
                ve = (ln > 9'd507) ? 9'($urandom_range(ln, 511)) :
                                     9'($urandom_range(ln, ln + 9'd4));
                hs = hbase + 9'($urandom_range(0, 8));
                ctl_mid = 5'($urandom);
                add_req(spse_pkg::OP_WRITE, 3'(s), spse_pkg::WR_POS,
                        {vs[7:0], hs[8:1]}, 9'd0, 9'd0);
                add_req(spse_pkg::OP_WRITE, 3'(s), spse_pkg::WR_CTL,
                        {ve[7:0], ctl_mid, vs[8], ve[8], hs[0]}, 9'd0, 9'd0);
                if ($urandom_range(0, 1) != 0)
                begin
                    hi = '0;
                    lo = '0;
                end
                else
                begin
                    hi = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 3));
                    lo = 16'($urandom);
                end
                add_req(spse_pkg::OP_WRITE, 3'(s), spse_pkg::WR_PTR_HI, hi, 9'd0, 9'd0);
                add_req(spse_pkg::OP_WRITE, 3'(s), spse_pkg::WR_PTR_LO, lo, 9'd0, 9'd0);
                add_req(spse_pkg::OP_WRITE, 3'(s), spse_pkg::WR_DATA_A,
                        ($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom), 9'd0, 9'd0);
                add_req(spse_pkg::OP_WRITE, 3'(s), spse_pkg::WR_DATA_B,
                        ($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom), 9'd0, 9'd0);
            end
        end
        add_req(spse_pkg::OP_LINE, 3'd0, 4'd0, 16'd0, ln, 9'd0);
        // Two words per sprite, interleaved, and now and then a stray third
        for (round = 0; round < 3; round++)
        begin
            for (s = 0; s < SPRITES; s++)
            begin
                if (used[s] && (round < 2 || $urandom_range(0, 3) == 0))
                begin
                    add_req(spse_pkg::OP_DMA, 3'(s), 4'd0, 16'($urandom), 9'd0, 9'd0);
                end
            end
        end
        for (k = 0; k < 20; k++)
        begin
            add_req(spse_pkg::OP_QUERY, 3'd0, 4'd0, 16'd0, 9'd0, hbase + 9'(k));
            add_req(spse_pkg::OP_SHIFT, 3'd0, 4'd0, 16'd0, 9'd0, 9'd0);
            if ($urandom_range(0, 5) == 0)
            begin
                add_req(spse_pkg::OP_READ, 3'($urandom_range(0, 7)),
                        4'($urandom_range(0, 8)), 16'd0, 9'd0, 9'd0);
            end
        end
    endtask

    // Fully random request, every field and bit free
    task automatic add_noise();
        add_req(3'($urandom), 3'($urandom), 4'($urandom), 16'($urandom),
                9'($urandom), 9'($urandom));
    endtask

    // Idle odds are redrawn on a free-running cycle count so that busy and quiet stretches alternate
    int cyc = 0;
    int idle_odds = 0;
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 64 == 0)
        begin
            idle_odds <= int'($urandom_range(0, 2));
        end
    end

    function automatic logic idle_start();
        if (req_q.size() < CALM_TAIL || idle_odds == 0)
        begin
            return 1'b0;
        end
        return $urandom_range(0, (idle_odds == 1) ? 15 : 3) == 0;
    endfunction

    // Request acceptance: predict and retire the request that went in
    logic req_stuck = 1'b0;
    always @(posedge clk)
    begin
        req_stuck = cmd_valid && cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            pixel_results.push_back(sprite_step(cmd));
            void'(req_q.pop_front());
        end
    end

    // Request driver
    int req_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (req_stuck)
        begin
            // hold the stalled request as it is
        end
        else if (req_gap > 0)
        begin
            req_gap   = req_gap - 1;
            cmd_valid <= 1'b0;
        end
        else if (req_q.size() == 0)
        begin
            cmd_valid <= 1'b0;
        end
        else if (idle_start())
        begin
            req_gap   = int'($urandom_range(1, 15)) - 1;
            cmd_valid <= 1'b0;
        end
        else
        begin
            cmd_valid <= 1'b1;
            cmd       <= req_q[0];
        end
    end

    // Result-side stall bursts
    int res_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else if (res_gap > 0)
        begin
            res_gap   = res_gap - 1;
            res_stall <= 1'b1;
        end
        else if (idle_start())
        begin
            res_gap   = int'($urandom_range(1, 15)) - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        spse_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pixel_results.size() == 0)
            begin
                $error("result with nothing outstanding: %h", res);
                errs++;
            end
            else
            begin
                want = pixel_results.pop_front();
                if (res.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, res.read_data);
                    errs++;
                end
                if (res.pixel !== want.pixel)
                begin
                    $error("pixel: expected %0d, got %0d", want.pixel, res.pixel);
                    errs++;
                end
                if (res.pixel_sprite !== want.pixel_sprite)
                begin
                    $error("pixel_sprite: expected %0d, got %0d",
                           want.pixel_sprite, res.pixel_sprite);
                    errs++;
                end
                if (res.dma_request !== want.dma_request)
                begin
                    $error("dma_request: expected %h, got %h",
                           want.dma_request, res.dma_request);
                    errs++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int n_directed;
        // Reset state, unknown selectors and opcodes, ignored data word
        add_req(spse_pkg::OP_READ, 3'd0, spse_pkg::RD_POS, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd3, SEL_BAD, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd4, SEL_GAP, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd2, SEL_BAD, 16'hffff, 9'd0, 9'd0);
        add_req(OP_SPARE_LO, 3'd7, SEL_BAD, 16'hffff, 9'h1ff, 9'h1ff);
        add_req(OP_SPARE_HI, 3'd0, 4'd0, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_DMA, 3'd1, 4'd0, 16'h1234, 9'd0, 9'd0);
        // All-ones registers and the derived fields
        add_req(spse_pkg::OP_WRITE, 3'd7, spse_pkg::WR_POS, 16'hffff, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd7, spse_pkg::WR_CTL, 16'hffff, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd7, spse_pkg::WR_PTR_HI, 16'hffff, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd7, spse_pkg::WR_PTR_LO, 16'hffff, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd7, spse_pkg::RD_HSTART, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd7, spse_pkg::RD_VSTART, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd7, spse_pkg::RD_VSTOP, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd7, spse_pkg::RD_ATTACHED, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd7, spse_pkg::RD_PTR, 16'd0, 9'd0, 9'd0);
        // Data write arms but does not show; the line start then shows it
        add_req(spse_pkg::OP_WRITE, 3'd0, spse_pkg::WR_CTL, 16'h0500, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd0, spse_pkg::WR_DATA_A, 16'h8001, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd0, spse_pkg::WR_DATA_B, 16'hffff, 9'd0, 9'd0);
        add_req(spse_pkg::OP_QUERY, 3'd0, 4'd0, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_LINE, 3'd0, 4'd0, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_QUERY, 3'd0, 4'd0, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_QUERY, 3'd0, 4'd0, 16'd0, 9'd0, 9'd16);
        add_req(spse_pkg::OP_SHIFT, 3'd0, 4'd0, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_QUERY, 3'd0, 4'd0, 16'd0, 9'd0, 9'd1);
        // Fetched sprite: pending words, two data words, pointer advance
        add_req(spse_pkg::OP_WRITE, 3'd1, spse_pkg::WR_POS, 16'h0a10, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd1, spse_pkg::WR_CTL, 16'h1400, 9'd0, 9'd0);
        add_req(spse_pkg::OP_WRITE, 3'd1, spse_pkg::WR_PTR_LO, 16'h0100, 9'd0, 9'd0);
        add_req(spse_pkg::OP_LINE, 3'd0, 4'd0, 16'd0, 9'd12, 9'd0);
        add_req(spse_pkg::OP_DMA, 3'd1, 4'd0, 16'hffff, 9'd0, 9'd0);
        add_req(spse_pkg::OP_DMA, 3'd1, 4'd0, 16'h0000, 9'd0, 9'd0);
        add_req(spse_pkg::OP_READ, 3'd1, spse_pkg::RD_PTR, 16'd0, 9'd0, 9'd0);
        add_req(spse_pkg::OP_QUERY, 3'd0, 4'd0, 16'd0, 9'd0, 9'h1ff);
        n_directed = req_q.size();

        // Mostly well-formed display lines, with bursts of noise
        while (req_q.size() < n_directed + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                add_scene();
            end
            else
            begin
                repeat (6) add_noise();
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || pixel_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (errs == 0 && pixel_results.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
